// File: sv/mpt_pkg.sv
// Shared package for the multichannel pulse timer.
// Holds the channel count, operation and status codes, register indexes and types.
// No dependencies.
package mpt_pkg;

  localparam int CHANNELS = 4;
  localparam int MASK_W   = 4;
  localparam int CFG_IDX_W = 8;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ARM    = 2'd1;
  localparam logic [1:0] OP_DISARM = 2'd2;
  localparam logic [1:0] OP_PULSE  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ARMED = 3'd1;
  localparam logic [2:0] ST_BAD_CHAN  = 3'd2;
  localparam logic [2:0] ST_BAD_DUR   = 3'd3;
  localparam logic [2:0] ST_TOO_SOON  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 8'd1;

  localparam logic [31:0] MAX_PULSE_RESET = 32'd1000;
  localparam logic [31:0] MIN_GAP_RESET   = 32'd1000;

  typedef struct packed {
    logic tick;
    logic clear;
    logic start;
  } chan_ctl_t;

  typedef struct packed {
    logic        too_soon;
    logic        on_now;
    logic        on_next;
    logic [31:0] remaining;
  } chan_stat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              accepted;
    logic              armed_now;
    logic [MASK_W-1:0] active_mask;
    logic              channel_active;
    logic [31:0]       remaining_ms;
  } result_t;

endpackage

// File: sv/mpt_cmd_if.sv
// Command channel interface for the multichannel pulse timer.
// Carries one operation per transfer; no dependencies.
interface mpt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  channel;
  logic [31:0] pulse_ms;

  modport source (output valid, operation, channel, pulse_ms, input ready);
  modport sink (input valid, operation, channel, pulse_ms, output ready);
endinterface

// File: sv/mpt_rsp_if.sv
// Result channel interface for the multichannel pulse timer.
// Carries one result per transfer; no dependencies.
interface mpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        accepted;
  logic        armed_now;
  logic [3:0]  active_mask;
  logic        channel_active;
  logic [31:0] remaining_ms;

  modport source (output valid, status, accepted, armed_now, active_mask,
                  channel_active, remaining_ms, input ready);
  modport sink (input valid, status, accepted, armed_now, active_mask,
                channel_active, remaining_ms, output ready);
endinterface

// File: sv/mpt_cfg_if.sv
// Configuration write channel interface for the multichannel pulse timer.
// Carries a register index and write data; no dependencies.
interface mpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/mpt_channel.sv
// State and per-item logic of one pulse channel: on flag, deadline, hold-off.
// Depends on mpt_pkg.
module mpt_channel (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  mpt_pkg::chan_ctl_t ctl,
  input  logic [31:0]        time_now,
  input  logic [31:0]        time_next,
  input  logic [31:0]        pulse_ms,
  input  logic [31:0]        min_gap_ms,
  output mpt_pkg::chan_stat_t stat
);

  logic        on;
  logic        ever;
  logic [31:0] deadline;
  logic [31:0] last_start;

  logic        on_next;
  logic [31:0] deadline_next;
  logic [31:0] elapsed;
  logic [31:0] tick_diff;
  logic [31:0] rem_diff;

  always_comb begin
    elapsed   = time_now - last_start;
    tick_diff = time_next - deadline;
    priority if (ctl.start) begin
      on_next = 1'b1;
    end else if (ctl.clear) begin
      on_next = 1'b0;
    end else if (ctl.tick && on && !tick_diff[31]) begin
      on_next = 1'b0;
    end else begin
      on_next = on;
    end
    deadline_next = ctl.start ? time_now + pulse_ms : deadline;
    rem_diff      = deadline_next - time_next;

    stat.too_soon  = ever && (elapsed < min_gap_ms);
    stat.on_now    = on;
    stat.on_next   = on_next;
    stat.remaining = (on_next && rem_diff != 32'd0 && !rem_diff[31]) ? rem_diff : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on         <= 1'b0;
      ever       <= 1'b0;
      deadline   <= 32'd0;
      last_start <= 32'd0;
    end else if (en) begin
      on       <= on_next;
      deadline <= deadline_next;
      if (ctl.start) begin
        ever       <= 1'b1;
        last_start <= time_now;
      end
    end
  end

endmodule

// File: sv/multichannel_pulse_timer.sv
// Multichannel one-shot pulse timer with arm interlock and per-channel hold-off.
// Takes one operation per transfer and returns one result for each; a new item is
// accepted in every cycle while the skid entry is empty. Each result is registered
// in the output register, or in the skid entry while it is held; this two-entry
// output buffer keeps the command side ready while one result waits. All channels are
// updated in parallel by their own logic. The configuration port is always ready.
// Depends on mpt_pkg, the three channel interfaces and mpt_channel.
module multichannel_pulse_timer (
  input  logic clk,
  input  logic rst,
  mpt_cmd_if.sink   cmd,
  mpt_rsp_if.source rsp,
  mpt_cfg_if.sink   cfg
);

  localparam int N = mpt_pkg::CHANNELS;

  logic [31:0] max_pulse_ms;
  logic [31:0] min_gap_ms;
  logic [31:0] time_now;
  logic        armed;

  logic        acc;
  logic [31:0] time_next;
  logic        armed_next;
  logic        ch_valid;
  logic        dur_bad;
  logic        too_soon_sel;
  logic [2:0]  status;
  logic [N-1:0] on_now_vec;

  mpt_pkg::chan_ctl_t  ctl  [N];
  mpt_pkg::chan_stat_t stat [N];
  mpt_pkg::chan_stat_t stat_sel;
  mpt_pkg::result_t    res;
  mpt_pkg::result_t    out_q;
  mpt_pkg::result_t    skid_q;
  logic                out_valid;
  logic                skid_valid;
  logic                take;

  assign cfg.ready = 1'b1;
  assign cmd.ready = !skid_valid;
  assign acc       = cmd.valid && cmd.ready;
  assign take      = out_valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pulse_ms <= mpt_pkg::MAX_PULSE_RESET;
      min_gap_ms   <= mpt_pkg::MIN_GAP_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == mpt_pkg::REG_MAX_PULSE) begin
        max_pulse_ms <= cfg.data;
      end else if (cfg.index == mpt_pkg::REG_MIN_GAP) begin
        min_gap_ms <= cfg.data;
      end
    end
  end

  always_comb begin
    ch_valid = (cmd.channel >= 4'd1) && (cmd.channel <= 4'(N));
    dur_bad  = (cmd.pulse_ms == 32'd0) || (cmd.pulse_ms > max_pulse_ms);
    time_next  = (cmd.operation == mpt_pkg::OP_TICK) ? time_now + 32'd1 : time_now;
    armed_next = armed;
    if (cmd.operation == mpt_pkg::OP_ARM) begin
      armed_next = 1'b1;
    end else if (cmd.operation == mpt_pkg::OP_DISARM) begin
      armed_next = 1'b0;
    end
    too_soon_sel = 1'b0;
    stat_sel     = '0;
    for (int i = 0; i < N; i++) begin
      if (cmd.channel == 4'(i + 1)) begin
        too_soon_sel = stat[i].too_soon;
        stat_sel     = stat[i];
      end
    end
    priority if (cmd.operation != mpt_pkg::OP_PULSE) begin
      status = mpt_pkg::ST_OK;
    end else if (!armed) begin
      status = mpt_pkg::ST_NOT_ARMED;
    end else if (!ch_valid) begin
      status = mpt_pkg::ST_BAD_CHAN;
    end else if (dur_bad) begin
      status = mpt_pkg::ST_BAD_DUR;
    end else if (too_soon_sel) begin
      status = mpt_pkg::ST_TOO_SOON;
    end else begin
      status = mpt_pkg::ST_OK;
    end
    for (int i = 0; i < N; i++) begin
      ctl[i].tick  = (cmd.operation == mpt_pkg::OP_TICK);
      ctl[i].clear = (cmd.operation == mpt_pkg::OP_DISARM);
      ctl[i].start = (cmd.operation == mpt_pkg::OP_PULSE) && (status == mpt_pkg::ST_OK)
                     && (cmd.channel == 4'(i + 1));
    end
    res.status   = status;
    res.accepted = (cmd.operation == mpt_pkg::OP_PULSE) && (status == mpt_pkg::ST_OK);
    res.armed_now = armed_next;
    res.active_mask = '0;
    for (int i = 0; i < mpt_pkg::MASK_W; i++) begin
      if (i < N) begin
        res.active_mask[i] = stat[i].on_next;
      end
    end
    res.channel_active = ch_valid && stat_sel.on_next;
    res.remaining_ms   = ch_valid ? stat_sel.remaining : 32'd0;
  end

  for (genvar g = 0; g < N; g++) begin : g_chan
    mpt_channel u_chan (
      .clk        (clk),
      .rst        (rst),
      .en         (acc),
      .ctl        (ctl[g]),
      .time_now   (time_now),
      .time_next  (time_next),
      .pulse_ms   (cmd.pulse_ms),
      .min_gap_ms (min_gap_ms),
      .stat       (stat[g])
    );
    assign on_now_vec[g] = stat[g].on_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= 32'd0;
      armed    <= 1'b0;
    end else if (acc) begin
      time_now <= time_next;
      armed    <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc;
      end
    end else if (acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res;
      end
    end else if (acc) begin
      skid_q <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_q.status;
  assign rsp.accepted       = out_q.accepted;
  assign rsp.armed_now      = out_q.armed_now;
  assign rsp.active_mask    = out_q.active_mask;
  assign rsp.channel_active = out_q.channel_active;
  assign rsp.remaining_ms   = out_q.remaining_ms;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid entry held while the output register is empty.");

  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.operation == mpt_pkg::OP_DISARM |=> on_now_vec == '0)
    else $error("A channel stayed on after a disarm transfer.");

  a_accept_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.accepted |-> rsp.status == mpt_pkg::ST_OK && rsp.armed_now)
    else $error("Accepted pulse reported with a failing status or disarmed.");

  a_idle_no_remaining: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.channel_active |-> rsp.remaining_ms == 32'd0)
    else $error("Time left reported on an inactive channel.");

endmodule

// File: bench/tb_multichannel_pulse_timer.sv
// Testbench for the multichannel pulse timer: directed checks, register extremes,
// random traffic under three flow-control mixes and a long result-side stall.
// Depends on mpt_pkg, the three channel interfaces and the multichannel_pulse_timer RTL.
module tb_multichannel_pulse_timer;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  channel;
    logic [31:0] pulse_ms;
  } command_t;

  logic clk = 1'b0;
  logic rst;

  mpt_cmd_if cmd_bus ();
  mpt_rsp_if rsp_bus ();
  mpt_cfg_if cfg_bus ();

  multichannel_pulse_timer uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [31:0]                  max_pulse_ms = mpt_pkg::MAX_PULSE_RESET;
  logic [31:0]                  min_gap_ms = mpt_pkg::MIN_GAP_RESET;
  logic [31:0]                  now_ms = '0;
  logic                         armed = 1'b0;
  logic [mpt_pkg::CHANNELS-1:0] chan_on = '0;
  logic [mpt_pkg::CHANNELS-1:0] chan_used = '0;
  logic [31:0]                  deadline_ms [mpt_pkg::CHANNELS] = '{default: '0};
  logic [31:0]                  started_ms [mpt_pkg::CHANNELS] = '{default: '0};

  mpt_pkg::result_t expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int errors = 0;
  int commands_sent = 0;
  int results_checked = 0;
  int pulses_started = 0;
  int holdoff_rejects = 0;

  function automatic mpt_pkg::result_t predict_timer(input command_t c);
    mpt_pkg::result_t r;
    int               k;
    logic [31:0]      gap;
    logic [31:0]      left;
    r = '0;
    if (c.operation == mpt_pkg::OP_TICK) begin
      now_ms = now_ms + 32'd1;
      for (k = 0; k < mpt_pkg::CHANNELS; k++) begin
        gap = now_ms - deadline_ms[k];
        if (chan_on[k] && !gap[31]) chan_on[k] = 1'b0;
      end
    end else if (c.operation == mpt_pkg::OP_ARM) begin
      armed = 1'b1;
    end else if (c.operation == mpt_pkg::OP_DISARM) begin
      armed = 1'b0;
      chan_on = '0;
    end else begin
      k = int'(c.channel) - 1;
      if (!armed) begin
        r.status = mpt_pkg::ST_NOT_ARMED;
      end else if (c.channel < 1 || c.channel > mpt_pkg::CHANNELS) begin
        r.status = mpt_pkg::ST_BAD_CHAN;
      end else if (c.pulse_ms == 32'd0 || c.pulse_ms > max_pulse_ms) begin
        r.status = mpt_pkg::ST_BAD_DUR;
      end else begin
        gap = now_ms - started_ms[k];
        if (chan_used[k] && gap < min_gap_ms) begin
          r.status = mpt_pkg::ST_TOO_SOON;
          holdoff_rejects++;
        end else begin
          chan_on[k] = 1'b1;
          deadline_ms[k] = now_ms + c.pulse_ms;
          started_ms[k] = now_ms;
          chan_used[k] = 1'b1;
          r.status = mpt_pkg::ST_OK;
          r.accepted = 1'b1;
          pulses_started++;
        end
      end
    end
    for (k = 0; k < mpt_pkg::CHANNELS && k < mpt_pkg::MASK_W; k++) begin
      r.active_mask[k] = chan_on[k];
    end
    if (c.channel >= 1 && c.channel <= mpt_pkg::CHANNELS) begin
      k = int'(c.channel) - 1;
      if (chan_on[k]) begin
        r.channel_active = 1'b1;
        left = deadline_ms[k] - now_ms;
        if (left != 32'd0 && !left[31]) r.remaining_ms = left;
      end
    end
    r.armed_now = armed;
    return r;
  endfunction

  function automatic command_t random_command();
    command_t    c;
    int          pick;
    logic [31:0] lim;
    pick = $urandom_range(99);
    c.operation = (pick < 40) ? mpt_pkg::OP_TICK : (pick < 47) ? mpt_pkg::OP_ARM :
                  (pick < 50) ? mpt_pkg::OP_DISARM : mpt_pkg::OP_PULSE;
    c.channel = ($urandom_range(99) < 85) ? 4'($urandom_range(mpt_pkg::CHANNELS, 1))
                                          : 4'($urandom());
    lim = (max_pulse_ms > 32'd64) ? 32'd64 : max_pulse_ms;
    pick = $urandom_range(99);
    if (pick < 75 && lim != 32'd0) c.pulse_ms = $urandom_range(lim, 1);
    else if (pick < 82) c.pulse_ms = '0;
    else if (pick < 90) c.pulse_ms = max_pulse_ms + 32'd1;
    else c.pulse_ms = $urandom();
    return c;
  endfunction

  task automatic send_cmd(input command_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.operation <= c.operation;
    cmd_bus.channel <= c.channel;
    cmd_bus.pulse_ms <= c.pulse_ms;
    // Hold the command until its transfer completes.
    do @(posedge clk); while (!cmd_bus.ready);
    expected_results.push_back(predict_timer(c));
    commands_sent++;
  endtask

  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == mpt_pkg::REG_MAX_PULSE) max_pulse_ms = value;
    else if (idx == mpt_pkg::REG_MIN_GAP) min_gap_ms = value;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  initial begin : result_checker
    mpt_pkg::result_t got;
    mpt_pkg::result_t want;
    int               hold_left;
    hold_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        got.status = rsp_bus.status;
        got.accepted = rsp_bus.accepted;
        got.armed_now = rsp_bus.armed_now;
        got.active_mask = rsp_bus.active_mask;
        got.channel_active = rsp_bus.channel_active;
        got.remaining_ms = rsp_bus.remaining_ms;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no command pending, expected none, got %p", $time, got);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("status", want.status, got.status);
          check_field("accepted", want.accepted, got.accepted);
          check_field("armed_now", want.armed_now, got.armed_now);
          check_field("active_mask", want.active_mask, got.active_mask);
          check_field("channel_active", want.channel_active, got.channel_active);
          check_field("remaining_ms", want.remaining_ms, got.remaining_ms);
        end
      end
      if (stall_request > 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic test_directed_checks();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_cmd('{mpt_pkg::OP_PULSE, 4'd1, 32'd10});
    send_cmd('{mpt_pkg::OP_ARM, 4'd0, $urandom()});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd0, 32'd10});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd15, 32'hFFFF_FFFF});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd1, 32'd0});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd1, mpt_pkg::MAX_PULSE_RESET + 32'd1});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd1, mpt_pkg::MAX_PULSE_RESET});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd1, 32'd5});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd2, 32'd1});
    send_cmd('{mpt_pkg::OP_TICK, 4'd2, $urandom()});
    send_cmd('{mpt_pkg::OP_TICK, 4'd1, $urandom()});
    send_cmd('{mpt_pkg::OP_DISARM, 4'd1, $urandom()});
  endtask

  task automatic test_register_extremes();
    write_reg(mpt_pkg::REG_MAX_PULSE, 32'hFFFF_FFFF);
    write_reg(mpt_pkg::REG_MIN_GAP, 32'd0);
    write_reg(8'($urandom_range(255, int'(mpt_pkg::REG_MIN_GAP) + 1)), $urandom());
    send_cmd('{mpt_pkg::OP_ARM, 4'd4, $urandom()});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd1, 32'h8000_0000});
    send_cmd('{mpt_pkg::OP_TICK, 4'd1, $urandom()});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd3, 32'h7FFF_FFFF});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd3, 32'd3});
    send_cmd('{mpt_pkg::OP_TICK, 4'd3, $urandom()});
    write_reg(mpt_pkg::REG_MAX_PULSE, 32'd0);
    write_reg(mpt_pkg::REG_MIN_GAP, 32'hFFFF_FFFF);
    send_cmd('{mpt_pkg::OP_PULSE, 4'd4, 32'd1});
    write_reg(mpt_pkg::REG_MAX_PULSE, 32'd1);
    send_cmd('{mpt_pkg::OP_PULSE, 4'd4, 32'd1});
    send_cmd('{mpt_pkg::OP_PULSE, 4'd4, 32'd1});
    send_cmd('{mpt_pkg::OP_TICK, 4'd4, $urandom()});
    send_cmd('{mpt_pkg::OP_DISARM, 4'd3, $urandom()});
  endtask

  task automatic test_random_traffic(input int count, input int sender_pct,
                                     input int receiver_pct, input logic [31:0] max_ms,
                                     input logic [31:0] gap_ms);
    int n;
    write_reg(mpt_pkg::REG_MAX_PULSE, max_ms);
    write_reg(mpt_pkg::REG_MIN_GAP, gap_ms);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (n = 0; n < count; n++) send_cmd(random_command());
  endtask

  task automatic test_output_backpressure();
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 80;
    for (n = 0; n < 40; n++) send_cmd(random_command());
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    cmd_bus.valid <= 1'b0;
    cmd_bus.operation <= mpt_pkg::OP_TICK;
    cmd_bus.channel <= '0;
    cmd_bus.pulse_ms <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= mpt_pkg::REG_MAX_PULSE;
    cfg_bus.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_checks();
    test_register_extremes();
    test_random_traffic(620, 22, 48, $urandom_range(48, 1), $urandom_range(12, 0));
    test_random_traffic(620, 48, 22, $urandom_range(48, 1), $urandom_range(12, 0));
    test_random_traffic(620, 0, 0, 32'hFFFF_FFFF, $urandom_range(16, 0));
    test_output_backpressure();
    wait_drained();
    repeat (16) @(posedge clk);
    $display("Drove %0d commands: directed checks, register extremes, three idle mixes and",
             commands_sent);
    $display("a long result stall; %0d results checked, %0d pulses started, %0d hold-off rejects.",
             results_checked, pulses_started, holdoff_rejects);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Run did not finish in time.");
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
sv/mpt_pkg.sv
sv/mpt_cmd_if.sv
sv/mpt_rsp_if.sv
sv/mpt_cfg_if.sv
sv/mpt_channel.sv
sv/multichannel_pulse_timer.sv
bench/tb_multichannel_pulse_timer.sv
